### hdl/tcrt_pkg.sv
// package for the three channel reload timer
// constants, register offsets and the prescaler table; no dependencies
`default_nettype none
package tcrt_pkg;
	localparam int CHANNELS_DEF = 3;
	localparam logic [5:0] OFF_START = 6'h04;
	localparam logic [5:0] OFF_CH0 = 6'h08;
	localparam int CH_STRIDE = 12;
	localparam logic [6:0] CTRL_WMASK = 7'h77;
	localparam int UNF_BIT = 5;
	localparam int UNIE_BIT = 6;
	localparam logic [1:0] FUNC_READ = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_TICK = 2'd2;
	localparam logic [10:0] IRQ_BASE = 11'h400;
	localparam logic [10:0] IRQ_STEP = 11'h020;

	// shift amount of the prescaler: divisors 4, 16, 64, 256
	function automatic logic [3:0] pre_shift(input logic [1:0] sel);
		case (sel)
			2'd0: pre_shift = 4'd2;
			2'd1: pre_shift = 4'd4;
			2'd2: pre_shift = 4'd6;
			default: pre_shift = 4'd8;
		endcase
	endfunction

	typedef struct packed {
		logic start;  // begin a modulo run
		logic busy;   // divider working
		logic done;   // result ready
	} div_if_t;
endpackage
`default_nettype wire

### hdl/tcrt_moddiv.sv
// sequential 33 by 33 bit restoring remainder unit, one bit a cycle
// uses tcrt_pkg for the handshake struct
`default_nettype none
module tcrt_moddiv (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [32:0] dividend,
	input  wire logic [32:0] divisor,
	output tcrt_pkg::div_if_t st,
	output logic      [32:0] rem
);
	logic [32:0] quo_q;
	logic [33:0] rem_q;
	logic [32:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q;
	logic [33:0] trial;

	assign trial = {rem_q[32:0], quo_q[32]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd33;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[31:0], 1'b0};
			if (!trial[33]) rem_q <= trial;
			else rem_q <= {rem_q[32:0], quo_q[32]};
		end
	end

	assign rem = rem_q[32:0];
	assign st = '{start: start, busy: busy_q, done: done_q};
endmodule
`default_nettype wire

### hdl/tcrt_datapath.sv
// register file, channel counters and result formation of the timer
// uses tcrt_pkg and tcrt_moddiv
`default_nettype none
module tcrt_datapath #(
	parameter int CHANNELS = tcrt_pkg::CHANNELS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        load,      // capture input beat
	input  wire logic [1:0]  func,
	input  wire logic [5:0]  offset,
	input  wire logic [31:0] write_data,
	input  wire logic [15:0] cycles,
	input  wire logic        do_access, // read/write
	input  wire logic        ch_eval,   // evaluate channel ch_sel
	input  wire logic        ch_div,    // start modulo for ch_sel
	input  wire logic        ch_fin,    // store modulo result
	input  wire logic [1:0]  ch_sel,
	input  wire logic        clr_pend,  // clear pending of ch_sel
	output logic             need_div,
	output tcrt_pkg::div_if_t dst,
	output logic             pend_irq,  // ch_sel pending with unie
	output logic             any_irq,   // another channel pending with unie
	output logic [31:0]      rdata
);
	logic [2:0]  start_q;
	logic [31:0] reload_q [CHANNELS];
	logic [31:0] count_q  [CHANNELS];
	logic [6:0]  ctrl_q   [CHANNELS];
	logic [7:0]  resid_q  [CHANNELS];
	logic [CHANNELS-1:0] pend_q;
	logic [1:0]  func_q;
	logic [5:0]  off_q;
	logic [31:0] wd_q;
	logic [15:0] cyc_q;

	// decode
	logic [5:0]  rel;
	logic [1:0]  dch;
	logic [3:0]  dr;
	logic        dvalid;
	logic [1:0]  dkind; // 0 start,1 reload,2 count,3 control

	always_comb begin
		rel = off_q - tcrt_pkg::OFF_CH0;
		if (rel < 6'd12) begin dch = 2'd0; dr = rel[3:0]; end
		else if (rel < 6'd24) begin dch = 2'd1; dr = 4'(rel - 6'd12); end
		else if (rel < 6'd36) begin dch = 2'd2; dr = 4'(rel - 6'd24); end
		else begin dch = 2'd3; dr = 4'(rel - 6'd36); end
		dvalid = 1'b0;
		dkind = 2'd0;
		if (off_q == tcrt_pkg::OFF_START) dvalid = 1'b1;
		else if (off_q >= tcrt_pkg::OFF_CH0 && 32'(dch) < CHANNELS) begin
			dvalid = (dr == 4'd0) || (dr == 4'd4) || (dr == 4'd8);
			dkind = (dr == 4'd0) ? 2'd1 : (dr == 4'd4) ? 2'd2 : 2'd3;
		end
	end

	// channel arithmetic
	logic [3:0]  sh;
	logic [23:0] total;
	logic [23:0] counts;
	logic [7:0]  mask;
	logic        started;
	logic [32:0] divr;
	logic [32:0] left;
	logic [32:0] rem;
	logic [1:0]  cs;

	assign cs = (32'(ch_sel) < CHANNELS) ? ch_sel : 2'd0;
	assign sh = tcrt_pkg::pre_shift(ctrl_q[cs][1:0]);
	assign total = 24'(resid_q[cs]) + 24'(cyc_q);
	assign counts = total >> sh;
	assign mask = 8'((9'd1 << sh) - 9'd1);
	assign started = start_q[ch_sel];
	assign need_div = started && counts != 24'd0 && {8'd0, counts} >= count_q[cs];
	assign divr = {1'b0, reload_q[cs]} + 33'd1;
	assign left = 33'(counts) - {1'b0, count_q[cs]};
	assign pend_irq = pend_q[cs] && ctrl_q[cs][tcrt_pkg::UNIE_BIT];

	// channels below ch_sel are already cleared while the results are walked
	always_comb begin
		any_irq = 1'b0;
		for (int i = 0; i < CHANNELS; i++)
			if (2'(i) != cs && pend_q[i] && ctrl_q[i][tcrt_pkg::UNIE_BIT]) any_irq = 1'b1;
	end

	tcrt_moddiv u_div (
		.clk(clk), .arst_n(arst_n), .start(ch_div), .dividend(left),
		.divisor(divr), .st(dst), .rem(rem)
	);

	always_ff @(posedge clk) begin
		if (load) begin
			func_q <= func;
			off_q <= offset;
			wd_q <= write_data;
			cyc_q <= cycles;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			pend_q <= '0;
			rdata <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				reload_q[i] <= '0;
				count_q[i] <= '0;
				ctrl_q[i] <= '0;
				resid_q[i] <= '0;
			end
		end else begin
			if (load) begin
				rdata <= '0;
				// underflows left from an earlier tick never reach a later beat
				pend_q <= '0;
			end
			if (do_access) begin
				if (func_q == tcrt_pkg::FUNC_READ && dvalid) begin
					case (dkind)
						2'd0: rdata <= {29'd0, start_q};
						2'd1: rdata <= reload_q[dch];
						2'd2: rdata <= count_q[dch];
						default: rdata <= {25'd0, ctrl_q[dch]};
					endcase
				end else if (func_q == tcrt_pkg::FUNC_WRITE && dvalid) begin
					case (dkind)
						2'd0: start_q <= wd_q[2:0];
						2'd1: reload_q[dch] <= wd_q;
						2'd2: count_q[dch] <= wd_q;
						default: ctrl_q[dch] <= wd_q[6:0] & tcrt_pkg::CTRL_WMASK;
					endcase
				end
			end
			if (ch_eval && started) begin
				resid_q[cs] <= total[7:0] & mask;
				if (!need_div) count_q[cs] <= count_q[cs] - {8'd0, counts};
			end
			if (ch_fin) begin
				count_q[cs] <= 32'(divr - 33'd1 - rem);
				ctrl_q[cs][tcrt_pkg::UNF_BIT] <= 1'b1;
				pend_q[cs] <= 1'b1;
			end
			if (clr_pend) pend_q[cs] <= 1'b0;
		end
	end
endmodule
`default_nettype wire

### hdl/tcrt_ctrl.sv
// sequencer of the timer: access, per-channel tick evaluation, result beats
// uses tcrt_pkg
`default_nettype none
module tcrt_ctrl #(
	parameter int CHANNELS = tcrt_pkg::CHANNELS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  func,
	output logic             load,
	output logic             do_access,
	output logic             ch_eval,
	output logic             ch_div,
	output logic             ch_fin,
	output logic [1:0]       ch_sel,
	output logic             clr_pend,
	input  wire logic        need_div,
	input  wire tcrt_pkg::div_if_t dst,
	input  wire logic        pend_irq,
	input  wire logic        any_irq,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             o_irq,
	output logic [1:0]       o_ch,
	output logic             o_last
);
	typedef enum logic [2:0] {S_IDLE, S_ACC, S_EVAL, S_DIVW, S_EMIT, S_OUT} st_t;
	st_t st_q;
	logic [1:0] ch_q;
	logic       tick_q, irq_seen_q;
	logic       last_ch;

	assign last_ch = 32'(ch_q) == CHANNELS - 1;
	assign in_ready = st_q == S_IDLE;
	assign load = in_valid && in_ready;
	assign do_access = st_q == S_ACC;
	assign ch_eval = st_q == S_EVAL;
	assign ch_div = st_q == S_EVAL && need_div;
	assign ch_fin = st_q == S_DIVW && dst.done;
	assign ch_sel = ch_q;
	assign clr_pend = st_q == S_EMIT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ch_q <= '0;
			tick_q <= 1'b0;
			irq_seen_q <= 1'b0;
			out_valid <= 1'b0;
			o_irq <= 1'b0;
			o_ch <= '0;
			o_last <= 1'b0;
		end else begin
			case (st_q)
				S_IDLE: if (load) begin
					tick_q <= func == tcrt_pkg::FUNC_TICK;
					st_q <= S_ACC;
				end
				S_ACC: begin
					ch_q <= '0;
					irq_seen_q <= 1'b0;
					st_q <= tick_q ? S_EVAL : S_EMIT;
				end
				S_EVAL: begin
					if (need_div) st_q <= S_DIVW;
					else if (last_ch) begin ch_q <= '0; st_q <= S_EMIT; end
					else ch_q <= ch_q + 2'd1;
				end
				S_DIVW: if (dst.done) begin
					if (last_ch) begin ch_q <= '0; st_q <= S_EMIT; end
					else begin ch_q <= ch_q + 2'd1; st_q <= S_EVAL; end
				end
				S_EMIT: begin
					// walk channels; emit a beat per pending unie channel, or one plain beat if none
					if (pend_irq) begin
						out_valid <= 1'b1;
						o_irq <= 1'b1;
						o_ch <= ch_q;
						irq_seen_q <= 1'b1;
						o_last <= last_ch || !any_irq;
						st_q <= S_OUT;
					end else if (last_ch) begin
						if (!irq_seen_q) begin
							out_valid <= 1'b1;
							o_irq <= 1'b0;
							o_ch <= '0;
							o_last <= 1'b1;
							st_q <= S_OUT;
						end else st_q <= S_IDLE;
					end else ch_q <= ch_q + 2'd1;
				end
				S_OUT: if (out_ready) begin
					out_valid <= 1'b0;
					if (o_last) st_q <= S_IDLE;
					else begin ch_q <= ch_q + 2'd1; st_q <= S_EMIT; end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	property p_last_ends;
		@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && o_last) |=> st_q == S_IDLE;
	endproperty
	a_last_ends: assert property (p_last_ends) else $error("last beat left block busy");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> !in_ready) else $error("accepted while busy");
	a_ch_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(ch_q) < CHANNELS) else $error("channel index out of range");
endmodule
`default_nettype wire

### hdl/three_channel_reload_timer.sv
// top level of the three channel reload timer
// uses tcrt_pkg, tcrt_ctrl, tcrt_datapath
// One beat at a time: a read or write shows its result in one output beat after the
// input beat. A tick evaluates the channels one per cycle unless one underflows: a
// channel that underflows waits while a one-bit-per-cycle remainder unit of 33 steps
// folds the overshoot into the reload period; results are then walked channel by
// channel, each earlier interrupt beat waiting until it is taken.
// s_tready rises right after the last result beat is taken.
`default_nettype none
module three_channel_reload_timer #(
	parameter int CHANNELS = tcrt_pkg::CHANNELS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [55:0] s_tdata,  // func[1:0], offset[7:2], write_data[39:8], cycles[55:40]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,  // read_data[31:0], irq_valid[32], irq_channel[34:33], irq_code[45:35]
	output logic             m_tlast
);
	logic load, do_access, ch_eval, ch_div, ch_fin, clr_pend;
	logic need_div, pend_irq, any_irq;
	logic [1:0] ch_sel, o_ch;
	logic o_irq;
	logic [31:0] rdata;
	tcrt_pkg::div_if_t dst;
	logic [10:0] code;

	tcrt_ctrl #(.CHANNELS(CHANNELS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.func(s_tdata[1:0]), .load(load), .do_access(do_access), .ch_eval(ch_eval),
		.ch_div(ch_div), .ch_fin(ch_fin), .ch_sel(ch_sel), .clr_pend(clr_pend),
		.need_div(need_div), .dst(dst), .pend_irq(pend_irq), .any_irq(any_irq),
		.out_valid(m_tvalid), .out_ready(m_tready), .o_irq(o_irq), .o_ch(o_ch),
		.o_last(m_tlast)
	);

	tcrt_datapath #(.CHANNELS(CHANNELS)) u_dp (
		.clk(clk), .arst_n(arst_n), .load(load), .func(s_tdata[1:0]),
		.offset(s_tdata[7:2]), .write_data(s_tdata[39:8]), .cycles(s_tdata[55:40]),
		.do_access(do_access), .ch_eval(ch_eval), .ch_div(ch_div), .ch_fin(ch_fin),
		.ch_sel(ch_sel), .clr_pend(clr_pend), .need_div(need_div), .dst(dst),
		.pend_irq(pend_irq), .any_irq(any_irq), .rdata(rdata)
	);

	assign code = tcrt_pkg::IRQ_BASE + 11'(o_ch) * tcrt_pkg::IRQ_STEP;
	assign m_tdata = {2'b00, (o_irq ? code : 11'd0), o_ch, o_irq,
		(o_irq ? 32'd0 : rdata)};
endmodule
`default_nettype wire
